// ----- sv/lpt_pkg.sv -----
package lpt_pkg;

    localparam int unsigned APB_ADDR_BITS     = 3;
    localparam int unsigned WORKER_COUNT_BITS = 5;
    localparam int unsigned OWN_WORKER_BITS   = 4;

    localparam logic [WORKER_COUNT_BITS-1:0] WORKER_COUNT_RESET = 5'd1;
    localparam logic [OWN_WORKER_BITS-1:0]   OWN_WORKER_RESET   = 4'd0;

    // register select, taken from paddr[2]
    localparam logic REG_WORKER_COUNT = 1'b0;
    localparam logic REG_OWN_WORKER   = 1'b1;

    typedef struct packed {
        logic [15:0] job_weight;
        logic        last_job;
    } t_in_item;

    typedef struct packed {
        logic [5:0] job_index;
        logic [3:0] worker;
        logic       keep;
        logic       overflow;
        logic       last_result;
    } t_out_item;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic start;
        logic commit;
        logic clear;
    } t_load_ctrl;

    typedef enum logic {
        S_IDLE,
        S_ASSIGN
    } t_state;

endpackage

// ----- sv/lpt_cell.sv -----
module lpt_cell import lpt_pkg::*; #(
    parameter int unsigned IDX = 0,
    parameter int unsigned WB  = 16,
    parameter int unsigned XW  = 6,
    parameter int unsigned CW  = 7
) (
    input  logic          i_clk,
    input  t_cell_ctrl    i_ctrl,
    input  logic [CW-1:0] i_count,
    input  logic [WB-1:0] i_new_w,
    input  logic [XW-1:0] i_new_idx,
    input  logic          i_left_keep,
    input  logic [WB-1:0] i_left_w,
    input  logic [XW-1:0] i_left_idx,
    input  logic [WB-1:0] i_right_w,
    input  logic [XW-1:0] i_right_idx,
    output logic          o_keep,
    output logic [WB-1:0] o_w,
    output logic [XW-1:0] o_idx
);

    logic [WB-1:0] r_w;
    logic [XW-1:0] r_idx;
    logic          w_live;

    assign w_live = CW'(IDX) < i_count;
    // equal weights stay ahead of the newcomer, which keeps the order stable
    assign o_keep = w_live && (r_w >= i_new_w);
    assign o_w    = r_w;
    assign o_idx  = r_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            if (!o_keep) begin
                if (i_left_keep) begin
                    r_w   <= i_new_w;
                    r_idx <= i_new_idx;
                end else begin
                    r_w   <= i_left_w;
                    r_idx <= i_left_idx;
                end
            end
        end else if (i_ctrl.shift) begin
            r_w   <= i_right_w;
            r_idx <= i_right_idx;
        end
    end

endmodule

// ----- sv/lpt_load_scan.sv -----
module lpt_load_scan import lpt_pkg::*; #(
    parameter int unsigned MAX_WORKERS = 16,
    parameter int unsigned WB          = 16,
    parameter int unsigned LW          = 22,
    localparam int unsigned WI = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
    localparam int unsigned NW = $clog2(MAX_WORKERS + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_load_ctrl             i_ctrl,
    input  logic [NW-1:0]          i_n,
    input  logic [WB-1:0]          i_weight,
    output logic                   o_done,
    output logic [WI-1:0]          o_best
);

    logic [LW-1:0]          r_mem [MAX_WORKERS];
    logic [MAX_WORKERS-1:0] r_valid;
    logic [WI-1:0]          r_addr;
    logic [WI-1:0]          r_rd_idx;
    logic                   r_issue;
    logic                   r_rd_vld;
    logic                   r_done;
    logic                   r_have;
    logic [WI-1:0]          r_best;
    logic [LW-1:0]          r_best_load;
    logic [LW-1:0]          r_rdata;
    logic                   r_rbit;

    logic [NW-1:0]          w_last_full;
    logic [WI-1:0]          w_last;
    logic [LW-1:0]          w_load;
    logic [LW-1:0]          w_sum;

    assign w_last_full = i_n - NW'(1);
    assign w_last      = w_last_full[WI-1:0];
    // a load never written since the set began reads as zero
    assign w_load      = r_rbit ? r_rdata : '0;
    assign w_sum       = r_best_load + LW'(i_weight);
    assign o_done      = r_done;
    assign o_best      = r_best;

    always_ff @(posedge i_clk) begin
        if (r_issue) begin
            r_rdata <= r_mem[r_addr];
            r_rbit  <= r_valid[r_addr];
        end
        if (i_ctrl.commit) begin
            r_mem[r_best] <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_valid <= '0;
            end else if (i_ctrl.commit) begin
                r_valid[r_best] <= 1'b1;
            end
            if (i_ctrl.commit) begin
                r_done <= 1'b0;
            end

            if (i_ctrl.start) begin
                r_addr  <= '0;
                r_issue <= 1'b1;
                r_have  <= 1'b0;
            end else if (r_issue) begin
                if (r_addr == w_last) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + WI'(1);
                end
            end

            r_rd_vld <= r_issue;
            r_rd_idx <= r_addr;

            // strict less-than keeps the lowest index on a tie
            if (r_rd_vld) begin
                if (!r_have || (w_load < r_best_load)) begin
                    r_best      <= r_rd_idx;
                    r_best_load <= w_load;
                end
                r_have <= 1'b1;
                if (r_rd_idx == w_last) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_done_not_scanning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_issue && !r_rd_vld)
        else $error("load scan reports done while still reading");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> !r_issue && !r_rd_vld)
        else $error("load scan started during a scan");

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (NW'(r_best) < i_n))
        else $error("chosen worker beyond worker count");
`endif

endmodule

// ----- sv/lpt_greedy_job_partitioner_top.sv -----
// a job not marked last is stored when accepted, or dropped once the cells are full;
// ready stays high while idle; after the last item, each job waits for the least-load
// scan over the effective worker count, reading one worker load per cycle from the
// load memory; the first scan starts when the last item is accepted
// reset is synchronous: counters, flags, state and the load valid flags clear at once;
// there is no clearing pass and the job cells hold no reset value
module lpt_greedy_job_partitioner_top import lpt_pkg::*; #(
    parameter int unsigned MAX_JOBS    = 64,
    parameter int unsigned MAX_WORKERS = 16,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_item,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int unsigned XW = $clog2(MAX_JOBS);
    localparam int unsigned CW = $clog2(MAX_JOBS + 1);
    localparam int unsigned WI = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int unsigned NW = $clog2(MAX_WORKERS + 1);
    localparam int unsigned LW = WEIGHT_BITS + $clog2(MAX_JOBS);
    localparam int unsigned KW = (WI > OWN_WORKER_BITS) ? WI : OWN_WORKER_BITS;

    t_state                       r_state;
    t_state                       n_state;
    logic [CW-1:0]                r_count;
    logic                         r_dropped;
    logic [WORKER_COUNT_BITS-1:0] r_worker_count;
    logic [OWN_WORKER_BITS-1:0]   r_own_worker;
    logic                         r_out_valid;
    t_out_item                    r_out_item;

    logic                         w_accept;
    logic                         w_full;
    logic                         w_space;
    logic                         w_commit;
    logic                         w_final;
    logic                         w_wr;
    logic [NW-1:0]                w_n;
    logic [WEIGHT_BITS-1:0]       w_new_w;
    logic [XW-1:0]                w_new_idx;
    logic                         w_done;
    logic [WI-1:0]                w_best;
    t_cell_ctrl                   w_cell_ctrl;
    t_load_ctrl                   w_load_ctrl;

    logic [WEIGHT_BITS-1:0]       w_cw [MAX_JOBS];
    logic [XW-1:0]                w_cidx [MAX_JOBS];
    logic                         w_ckeep [MAX_JOBS];

    assign pready      = 1'b1;
    assign w_wr        = psel && penable && pwrite;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_new_w   = WEIGHT_BITS'(i_in_item.job_weight);
    assign w_new_idx = r_count[XW-1:0];
    assign w_full    = (r_count == CW'(MAX_JOBS));
    assign w_space   = !r_out_valid || i_out_ready;

    // worker count zero acts as one, above the array size it saturates
    always_comb begin
        if (r_worker_count == '0) begin
            w_n = NW'(1);
        end else if (32'(r_worker_count) > MAX_WORKERS) begin
            w_n = NW'(MAX_WORKERS);
        end else begin
            w_n = NW'(r_worker_count);
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WORKER_COUNT: prdata = 32'(r_worker_count);
            REG_OWN_WORKER:   prdata = 32'(r_own_worker);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_in_item.last_job) begin
                    n_state = S_ASSIGN;
                end
            end
            S_ASSIGN: begin
                if (w_final) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready         = (r_state == S_IDLE);
        w_accept           = i_in_valid && o_in_ready;
        w_commit           = (r_state == S_ASSIGN) && w_done && w_space;
        w_final            = w_commit && (r_count == CW'(1));
        w_cell_ctrl.ins    = w_accept && !w_full;
        w_cell_ctrl.shift  = w_commit;
        w_load_ctrl.start  = (w_accept && i_in_item.last_job) || (w_commit && !w_final);
        w_load_ctrl.commit = w_commit;
        w_load_ctrl.clear  = w_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_dropped      <= 1'b0;
            r_worker_count <= WORKER_COUNT_RESET;
            r_own_worker   <= OWN_WORKER_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cell_ctrl.ins) begin
                r_count <= r_count + CW'(1);
            end else if (w_commit) begin
                r_count <= r_count - CW'(1);
            end
            if (w_final) begin
                r_dropped <= 1'b0;
            end else if (w_accept && w_full) begin
                r_dropped <= 1'b1;
            end
            if (w_wr) begin
                unique case (paddr[2])
                    REG_WORKER_COUNT: r_worker_count <= pwdata[WORKER_COUNT_BITS-1:0];
                    REG_OWN_WORKER:   r_own_worker   <= pwdata[OWN_WORKER_BITS-1:0];
                    default:          ;
                endcase
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // head cell holds the heaviest job still waiting
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_item.job_index   <= 6'(w_cidx[0]);
            r_out_item.worker      <= 4'(w_best);
            r_out_item.keep        <= (KW'(w_best) == KW'(r_own_worker));
            r_out_item.overflow    <= r_dropped;
            r_out_item.last_result <= (r_count == CW'(1));
        end
    end

    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        logic                   w_lkeep;
        logic [WEIGHT_BITS-1:0] w_lw;
        logic [XW-1:0]          w_lidx;
        logic [WEIGHT_BITS-1:0] w_rw;
        logic [XW-1:0]          w_ridx;

        if (g == 0) begin : g_head
            assign w_lkeep = 1'b1;
            assign w_lw    = w_new_w;
            assign w_lidx  = w_new_idx;
        end else begin : g_body
            assign w_lkeep = w_ckeep[g-1];
            assign w_lw    = w_cw[g-1];
            assign w_lidx  = w_cidx[g-1];
        end

        if (g == MAX_JOBS - 1) begin : g_tail
            assign w_rw   = w_cw[g];
            assign w_ridx = w_cidx[g];
        end else begin : g_next
            assign w_rw   = w_cw[g+1];
            assign w_ridx = w_cidx[g+1];
        end

        lpt_cell #(
            .IDX (g),
            .WB  (WEIGHT_BITS),
            .XW  (XW),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_cell_ctrl),
            .i_count     (r_count),
            .i_new_w     (w_new_w),
            .i_new_idx   (w_new_idx),
            .i_left_keep (w_lkeep),
            .i_left_w    (w_lw),
            .i_left_idx  (w_lidx),
            .i_right_w   (w_rw),
            .i_right_idx (w_ridx),
            .o_keep      (w_ckeep[g]),
            .o_w         (w_cw[g]),
            .o_idx       (w_cidx[g])
        );
    end

    lpt_load_scan #(
        .MAX_WORKERS (MAX_WORKERS),
        .WB          (WEIGHT_BITS),
        .LW          (LW)
    ) u_load_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_load_ctrl),
        .i_n      (w_n),
        .i_weight (w_cw[0]),
        .o_done   (w_done),
        .o_best   (w_best)
    );

`ifndef ASSERT_OFF
    a_assign_has_jobs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ASSIGN) |-> (r_count != '0))
        else $error("assignment running with no stored jobs");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_final |=> (r_state == S_IDLE) && (r_count == '0) && !r_dropped)
        else $error("set state not cleared after final item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_JOBS))
        else $error("job count beyond capacity");

    a_commit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid && (r_out_item.last_result == $past(w_final)))
        else $error("assigned item not registered at output");
`endif

endmodule
